@@ hw/rtl/itp_pkg.sv @@
// Package: shared types, codes and helpers of the integer-to-text formatter.
package itp_pkg;

    localparam int MAX_CHARS_DEF = 64;
    localparam int CNT_W         = 7;
    localparam int NDIG          = 22;
    localparam int DIDX_W        = 5;
    localparam int VAL_W         = 64;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X_UPPER = 8'h58;
    localparam logic [7:0] CH_X_LOWER = 8'h78;
    localparam logic [7:0] CH_A_UPPER = 8'h41;
    localparam logic [7:0] CH_A_LOWER = 8'h61;

    typedef enum logic [1:0] {
        FN_SDEC = 2'd0,
        FN_UDEC = 2'd1,
        FN_OCT  = 2'd2,
        FN_HEX  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_LAYOUT,
        ST_EMIT
    } t_state;

    typedef logic [NDIG-1:0][3:0] t_digs;

    typedef struct packed {
        logic [CNT_W-1:0]  lead;
        logic              sgn;
        logic [7:0]        sign_ch;
        logic              p0;
        logic              px;
        logic              upper;
        logic [CNT_W-1:0]  zc;
        logic [DIDX_W-1:0] nd;
        logic [CNT_W-1:0]  trail;
    } t_layout;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = (upper ? CH_A_UPPER : CH_A_LOWER) + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/integer_to_padded_text.sv @@
// Top level: printf-style integer to text formatter, one character per output request.
// Sequence: the request is taken, decimal values pass the shift/add-3 conversion (octal and hex
// skip it), leading zero digits are scanned off, the layout is computed and the first character
// is loaded, then one character per cycle (up to MAX_CHARS) while output is ready.
// Throughput: one request at a time; the input is ready again when the sequencer returns to
// idle after the last character is in the output register. Reset clears sequencer and valid.
module integer_to_padded_text
    import itp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // value[63:0], width[70:64], precision[77:71], left_align[78], zero_pad[79],
    // plus_sign[80], space_sign[81], alt_form[82], uppercase[83], zeros above
    input  logic [87:0] i_s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_char[7:0]
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    localparam logic [7:0] MAXC = 8'(MAX_CHARS);

    t_state            r_state, n_state;
    logic [5:0]        r_step, n_step;
    logic [DIDX_W-1:0] r_nd, n_nd;
    t_func             r_func;
    logic [CNT_W-1:0]  r_width, r_prec;
    logic              r_left, r_zpad, r_plus, r_space, r_alt, r_upper, r_neg, r_nz;

    logic              accept;
    t_func             in_func;
    logic [VAL_W-1:0]  in_value, in_mag;
    logic              in_neg;
    t_digs             dig;
    logic              dig_load, dig_step, emit_start, emit_busy;
    logic              scan_zero;
    t_layout           lay;

    logic              sgn;
    logic [7:0]        w_c, p_c, nd_e, zeros0, avail, zeros, body, pad, pfx;
    logic              p0, px;

    assign in_func  = t_func'(i_s_axis_tuser);
    assign in_value = i_s_axis_tdata[63:0];
    assign in_neg   = (in_func == FN_SDEC) && in_value[VAL_W-1];
    assign in_mag   = in_neg ? (VAL_W'(0) - in_value) : in_value;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign scan_zero = (r_nd > DIDX_W'(1)) && (dig[r_nd - DIDX_W'(1)] == 4'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (in_func == FN_SDEC || in_func == FN_UDEC) ? ST_CONV : ST_SCAN;
                end
            end
            ST_CONV: begin
                if (r_step == 6'd63) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!scan_zero) begin
                    n_state = ST_LAYOUT;
                end
            end
            ST_LAYOUT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!emit_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        dig_load        = 1'b0;
        dig_step        = 1'b0;
        emit_start      = 1'b0;
        n_step          = r_step;
        n_nd            = r_nd;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                dig_load        = accept;
                n_step          = '0;
                n_nd            = DIDX_W'(NDIG);
            end
            ST_CONV: begin
                dig_step = 1'b1;
                n_step   = r_step + 6'd1;
            end
            ST_SCAN: begin
                if (scan_zero) begin
                    n_nd = r_nd - DIDX_W'(1);
                end
            end
            ST_LAYOUT: begin
                emit_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sgn    = (r_func == FN_SDEC) && (r_neg || r_plus || r_space);
        w_c    = ({1'b0, r_width} > MAXC) ? MAXC : {1'b0, r_width};
        p_c    = ({1'b0, r_prec} > MAXC) ? MAXC : {1'b0, r_prec};
        nd_e   = {3'd0, r_nd};
        zeros0 = (p_c > nd_e) ? (p_c - nd_e) : 8'd0;
        px     = r_alt && (r_func == FN_HEX) && r_nz;
        p0     = (r_alt && (r_func == FN_OCT) && r_nz && (zeros0 == 8'd0)) || px;
        pfx    = {7'd0, p0} + {7'd0, px};
        avail  = MAXC - {7'd0, sgn} - pfx - nd_e;
        zeros  = (zeros0 > avail) ? avail : zeros0;
        body   = {7'd0, sgn} + pfx + zeros + nd_e;
        pad    = (w_c > body) ? (w_c - body) : 8'd0;

        lay.lead    = (!r_left && !r_zpad) ? pad[CNT_W-1:0] : '0;
        lay.sgn     = sgn;
        lay.sign_ch = r_neg ? CH_MINUS : (r_plus ? CH_PLUS : CH_SPACE);
        lay.p0      = p0;
        lay.px      = px;
        lay.upper   = r_upper;
        lay.zc      = zeros[CNT_W-1:0] + ((!r_left && r_zpad) ? pad[CNT_W-1:0] : CNT_W'(0));
        lay.nd      = r_nd;
        lay.trail   = r_left ? pad[CNT_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_step <= n_step;
        r_nd   <= n_nd;
        if (accept) begin
            r_func  <= in_func;
            r_width <= i_s_axis_tdata[70:64];
            r_prec  <= i_s_axis_tdata[77:71];
            r_left  <= i_s_axis_tdata[78];
            r_zpad  <= i_s_axis_tdata[79];
            r_plus  <= i_s_axis_tdata[80];
            r_space <= i_s_axis_tdata[81];
            r_alt   <= i_s_axis_tdata[82];
            r_upper <= i_s_axis_tdata[83];
            r_neg   <= in_neg;
            r_nz    <= (in_value != '0);
        end
    end

    itp_digits u_digits (
        .i_clk  (i_clk),
        .i_load (dig_load),
        .i_func (in_func),
        .i_mag  (in_mag),
        .i_step (dig_step),
        .o_dig  (dig)
    );

    itp_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (emit_start),
        .i_layout (lay),
        .i_dig    (dig),
        .o_busy   (emit_busy),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_char   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast)
    );

endmodule

@@ hw/rtl/itp_digits.sv @@
// Digit register with a shift/add-3 unit for binary to decimal conversion; octal and hex digits are loaded directly.
module itp_digits
    import itp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_load,
    input  t_func            i_func,
    input  logic [VAL_W-1:0] i_mag,
    input  logic             i_step,
    output t_digs            o_dig
);

    logic [VAL_W-1:0] r_bin;
    t_digs            r_bcd;
    logic [VAL_W-1:0] n_bin;
    t_digs            n_bcd;
    t_digs            adj;
    logic [4*NDIG-1:0] adj_bits;
    t_digs            ld_dig;
    logic [3*NDIG-1:0] oct_v;

    assign adj_bits = adj;

    always_comb begin
        oct_v = {{(3*NDIG-VAL_W){1'b0}}, i_mag};
        for (int k = 0; k < NDIG; k++) begin
            unique case (i_func)
                FN_HEX: begin
                    ld_dig[k] = (k < VAL_W/4) ? i_mag[4*(k % (VAL_W/4)) +: 4] : 4'd0;
                end
                FN_OCT: begin
                    ld_dig[k] = {1'b0, oct_v[3*k +: 3]};
                end
                default: begin
                    ld_dig[k] = 4'd0;
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            adj[k] = (r_bcd[k] >= 4'd5) ? (r_bcd[k] + 4'd3) : r_bcd[k];
        end
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_load) begin
            n_bin = i_mag;
            n_bcd = ld_dig;
        end else if (i_step) begin
            n_bcd = {adj_bits[4*NDIG-2:0], r_bin[VAL_W-1]};
            n_bin = {r_bin[VAL_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_dig = r_bcd;

endmodule

@@ hw/rtl/itp_emit.sv @@
// Character generator: walks the field layout and drives the output register.
module itp_emit
    import itp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_layout    i_layout,
    input  t_digs      i_dig,
    output logic       o_busy,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char,
    output logic       o_last
);

    logic [CNT_W-1:0]  r_lead, n_lead;
    logic              r_sgn, n_sgn;
    logic [7:0]        r_sign_ch, n_sign_ch;
    logic              r_p0, n_p0;
    logic              r_px, n_px;
    logic              r_upper, n_upper;
    logic [CNT_W-1:0]  r_zc, n_zc;
    logic [DIDX_W-1:0] r_dleft, n_dleft;
    logic [CNT_W-1:0]  r_trail, n_trail;
    logic              r_ov, n_ov;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic [3:0]        cur_d;
    logic              busy;

    assign busy  = (|r_lead) | r_sgn | r_p0 | r_px | (|r_zc) | (|r_dleft) | (|r_trail);
    assign cur_d = i_dig[r_dleft - DIDX_W'(1)];

    always_comb begin
        n_lead    = r_lead;
        n_sgn     = r_sgn;
        n_sign_ch = r_sign_ch;
        n_p0      = r_p0;
        n_px      = r_px;
        n_upper   = r_upper;
        n_zc      = r_zc;
        n_dleft   = r_dleft;
        n_trail   = r_trail;
        n_ov      = r_ov;
        n_char    = r_char;
        n_last    = r_last;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        if (i_start) begin
            n_lead    = i_layout.lead;
            n_sgn     = i_layout.sgn;
            n_sign_ch = i_layout.sign_ch;
            n_p0      = i_layout.p0;
            n_px      = i_layout.px;
            n_upper   = i_layout.upper;
            n_zc      = i_layout.zc;
            n_dleft   = i_layout.nd;
            n_trail   = i_layout.trail;
        end else if (busy && (!r_ov || i_ready)) begin
            n_ov   = 1'b1;
            n_last = 1'b0;
            priority if (r_lead != '0) begin
                n_char = CH_SPACE;
                n_lead = r_lead - CNT_W'(1);
            end else if (r_sgn) begin
                n_char = r_sign_ch;
                n_sgn  = 1'b0;
            end else if (r_p0) begin
                n_char = CH_ZERO;
                n_p0   = 1'b0;
            end else if (r_px) begin
                n_char = r_upper ? CH_X_UPPER : CH_X_LOWER;
                n_px   = 1'b0;
            end else if (r_zc != '0) begin
                n_char = CH_ZERO;
                n_zc   = r_zc - CNT_W'(1);
            end else if (r_dleft != '0) begin
                n_char  = digit_char(cur_d, r_upper);
                n_dleft = r_dleft - DIDX_W'(1);
                n_last  = (r_dleft == DIDX_W'(1)) && (r_trail == '0);
            end else begin
                n_char  = CH_SPACE;
                n_trail = r_trail - CNT_W'(1);
                n_last  = (r_trail == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= '0;
            r_sgn   <= 1'b0;
            r_p0    <= 1'b0;
            r_px    <= 1'b0;
            r_zc    <= '0;
            r_dleft <= '0;
            r_trail <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_lead  <= n_lead;
            r_sgn   <= n_sgn;
            r_p0    <= n_p0;
            r_px    <= n_px;
            r_zc    <= n_zc;
            r_dleft <= n_dleft;
            r_trail <= n_trail;
            r_ov    <= n_ov;
        end
        r_sign_ch <= n_sign_ch;
        r_upper   <= n_upper;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_busy  = busy;
    assign o_valid = r_ov;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule
